>>> hw/rtl/rgba_image_similarity_score_defines.svh
// assertion macros for the rgba image similarity score block
// used by rgba_image_similarity_score.sv, no other dependencies
`ifndef RGBA_IMAGE_SIMILARITY_SCORE_DEFINES_SVH
`define RGBA_IMAGE_SIMILARITY_SCORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RGBSIM_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbsim assertion failed");

// next-cycle implication
`define RGBSIM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbsim assertion failed");

`else

`define RGBSIM_ASSERT(label, clk, rst_n, ante, cons)

`define RGBSIM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/rgbsim_pkg.sv
// constants, widths and helper functions of the rgba image similarity score block
// no dependencies, used by rgba_image_similarity_score.sv
package rgbsim_pkg;

    // largest supported image size
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // field widths
    localparam int CH_W   = 8;
    localparam int SIZE_W = 13;
    localparam int SUM_W  = 35;
    localparam int PX_W   = CH_W + 2;
    localparam int Q_W    = 17;

    // pixel counters
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int CMP_W = SIZE_W + 2;

    // divisor path: d = 1020 * w * h = (p << 10) - (p << 2)
    localparam int PROD_W = 2 * SIZE_W;
    localparam int D_W    = PROD_W + 10;
    localparam int ALU_W  = D_W + 1;

    // restoring division, one quotient bit a step
    localparam int DIV_STEPS = Q_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // reset value of both size registers
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

    // register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // zero reads as one, oversize reads as the top
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                      input int top);
        logic [CMP_W-1:0] top_c;
        top_c = CMP_W'(top);
        if (v == '0) begin
            return SIZE_W'(1);
        end else if (CMP_W'(v) > top_c) begin
            return top_c[SIZE_W-1:0];
        end else begin
            return v;
        end
    endfunction

    function automatic logic [CH_W-1:0] abs_diff8(input logic [CH_W-1:0] a,
                                                   input logic [CH_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

>>> hw/rtl/rgba_image_similarity_score.sv
// top level of the rgba image similarity score block
// depends on rgbsim_pkg.sv and rgba_image_similarity_score_defines.svh

// Takes one request per cycle, each a pair of RGBA pixels from two images in
// raster order, and adds the four absolute channel differences to a running
// sum. The last pixel of an image (width times height, from the two size
// registers, zero read as one and oversize read as 4096) starts the score
// computation: width*height on a small multiplier, then the 1020x scaling,
// the saturating subtraction from the full-scale divisor and the steps of
// a restoring divider, these on one shared subtractor, then a load of the
// output register. The input side therefore stalls after each last pixel
// until that load, which also waits while the previous score still sits
// unaccepted in the output register; other pixels are taken unstalled.
// The score is floor((D - sum) * 65536 / D) with D = 1020*width*height,
// unsigned Q1.16, 0 when the sum exceeds D. The user must write the size
// registers only while the block is idle; the block does not enforce it.

`include "rgba_image_similarity_score_defines.svh"

module rgba_image_similarity_score (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_index,
    input  logic [rgbsim_pkg::SIZE_W-1:0]    i_cfg_data,
    // pixel request channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [rgbsim_pkg::CH_W-1:0]      i_a_red,
    input  logic [rgbsim_pkg::CH_W-1:0]      i_a_green,
    input  logic [rgbsim_pkg::CH_W-1:0]      i_a_blue,
    input  logic [rgbsim_pkg::CH_W-1:0]      i_a_alpha,
    input  logic [rgbsim_pkg::CH_W-1:0]      i_b_red,
    input  logic [rgbsim_pkg::CH_W-1:0]      i_b_green,
    input  logic [rgbsim_pkg::CH_W-1:0]      i_b_blue,
    input  logic [rgbsim_pkg::CH_W-1:0]      i_b_alpha,
    // score request channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [rgbsim_pkg::Q_W-1:0]       o_score
);

    // sequencer codes
    localparam logic [2:0] S_ACC  = 3'd0;  // taking pixels
    localparam logic [2:0] S_MUL  = 3'd1;  // width * height
    localparam logic [2:0] S_SCL  = 3'd2;  // times 1020
    localparam logic [2:0] S_NUM  = 3'd3;  // d - sum, saturated
    localparam logic [2:0] S_DIV  = 3'd4;  // quotient bits
    localparam logic [2:0] S_LOAD = 3'd5;  // into the output register

    localparam int ALU_W  = rgbsim_pkg::ALU_W;
    localparam int CMP_W  = rgbsim_pkg::CMP_W;
    localparam int Q_W    = rgbsim_pkg::Q_W;
    localparam int SIZE_W = rgbsim_pkg::SIZE_W;

    logic [2:0]                          r_state;
    logic [SIZE_W-1:0]                   r_width;
    logic [SIZE_W-1:0]                   r_height;
    logic [rgbsim_pkg::SUM_W-1:0]        r_sum;
    logic [rgbsim_pkg::COL_W-1:0]        r_col;
    logic [rgbsim_pkg::ROW_W-1:0]        r_row;
    logic [rgbsim_pkg::PROD_W-1:0]       r_prod;
    logic [rgbsim_pkg::D_W-1:0]          r_d;
    logic [ALU_W-1:0]                    r_rem;
    logic [Q_W-1:0]                      r_quot;
    logic [rgbsim_pkg::STEP_W-1:0]       r_step;
    logic                                r_out_valid;
    logic [Q_W-1:0]                      r_score;

    logic [SIZE_W-1:0]                   w_eff;
    logic [SIZE_W-1:0]                   h_eff;
    logic [rgbsim_pkg::PX_W-1:0]         px_diff;
    logic [rgbsim_pkg::SUM_W-1:0]        n_sum;
    logic [CMP_W-1:0]                    col_next;
    logic [CMP_W-1:0]                    row_next;
    logic                                row_end;
    logic                                img_end;
    logic                                in_take;
    logic                                out_free;

    // shared subtract / compare unit
    logic [ALU_W-1:0]                    alu_a;
    logic [ALU_W-1:0]                    alu_b;
    logic [ALU_W:0]                      alu_diff;
    logic                                alu_borrow;
    logic [ALU_W-1:0]                    n_rem;
    logic                                q_bit;

    assign w_eff = rgbsim_pkg::clamp_size(r_width, rgbsim_pkg::MAX_WIDTH);
    assign h_eff = rgbsim_pkg::clamp_size(r_height, rgbsim_pkg::MAX_HEIGHT);

    assign o_in_stall  = (r_state != S_ACC);
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_score     = r_score;

    // four channel differences of one pixel pair
    assign px_diff = rgbsim_pkg::PX_W'(rgbsim_pkg::abs_diff8(i_a_red,   i_b_red))
                   + rgbsim_pkg::PX_W'(rgbsim_pkg::abs_diff8(i_a_green, i_b_green))
                   + rgbsim_pkg::PX_W'(rgbsim_pkg::abs_diff8(i_a_blue,  i_b_blue))
                   + rgbsim_pkg::PX_W'(rgbsim_pkg::abs_diff8(i_a_alpha, i_b_alpha));
    assign n_sum   = r_sum + rgbsim_pkg::SUM_W'(px_diff);

    // row and image end, against the size in force now
    assign col_next = CMP_W'(r_col) + CMP_W'(1);
    assign row_next = CMP_W'(r_row) + CMP_W'(1);
    assign row_end  = (col_next >= CMP_W'(w_eff));
    assign img_end  = row_end && (row_next >= CMP_W'(h_eff));

    // operand selection for the shared unit
    always_comb begin
        case (r_state)
            S_SCL: begin
                alu_a = ALU_W'({r_prod, 10'b0});
                alu_b = ALU_W'({r_prod, 2'b0});
            end
            S_NUM: begin
                alu_a = ALU_W'(r_d);
                alu_b = ALU_W'(r_sum);
            end
            S_DIV: begin
                alu_a = r_rem;
                alu_b = ALU_W'(r_d);
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_borrow = alu_diff[ALU_W];

    // one restoring step: keep the difference when the divisor fits
    assign q_bit = !alu_borrow;
    assign n_rem = q_bit ? alu_diff[ALU_W-1:0] : r_rem;

    // size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= rgbsim_pkg::SIZE_RESET;
            r_height <= rgbsim_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rgbsim_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                rgbsim_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer, accumulator and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_sum   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_step  <= '0;
        end else begin
            case (r_state)
                S_ACC: begin
                    if (in_take) begin
                        r_sum <= n_sum;
                        if (!row_end) begin
                            r_col <= rgbsim_pkg::COL_W'(col_next);
                        end else begin
                            r_col <= '0;
                            if (img_end) begin
                                r_row   <= '0;
                                r_state <= S_MUL;
                            end else begin
                                r_row <= rgbsim_pkg::ROW_W'(row_next);
                            end
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_SCL;
                end
                S_SCL: begin
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_step <= r_step + rgbsim_pkg::STEP_W'(1);
                    if (r_step == rgbsim_pkg::STEP_W'(rgbsim_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    // wait for the output register to be free
                    if (out_free) begin
                        r_sum   <= '0;
                        r_state <= S_ACC;
                    end
                end
                default: begin
                    r_state <= S_ACC;
                end
            endcase
        end
    end

    // datapath of the score computation
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_MUL: begin
                r_prod <= rgbsim_pkg::PROD_W'(w_eff) * rgbsim_pkg::PROD_W'(h_eff);
            end
            S_SCL: begin
                r_d <= alu_diff[rgbsim_pkg::D_W-1:0];
            end
            S_NUM: begin
                // sum above the divisor saturates the score at zero
                r_rem  <= alu_borrow ? '0 : alu_diff[ALU_W-1:0];
                r_quot <= '0;
            end
            S_DIV: begin
                r_quot <= {r_quot[Q_W-2:0], q_bit};
                r_rem  <= {n_rem[ALU_W-2:0], 1'b0};
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_LOAD && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && out_free) begin
            r_score <= r_quot;
        end
    end

    // last pixel of an image closes the input side
    `RGBSIM_ASSERT_NEXT(a_last_stalls, i_clk, i_rst_n, in_take && img_end, o_in_stall)
    // score never above one in q1.16
    `RGBSIM_ASSERT(a_score_range, i_clk, i_rst_n, r_out_valid, o_score <= Q_W'(65536))
    // divider step count stays within the quotient width
    `RGBSIM_ASSERT(a_step_range, i_clk, i_rst_n, r_state == S_DIV,
                   r_step <= rgbsim_pkg::STEP_W'(rgbsim_pkg::DIV_STEPS - 1))
    // a held score is not overwritten
    `RGBSIM_ASSERT_NEXT(a_score_hold, i_clk, i_rst_n, r_out_valid && i_out_stall,
                        r_out_valid && (r_score == $past(r_score)))

endmodule

>>> verif/tb_rgba_image_similarity_score.sv
// self-checking testbench for rgba_image_similarity_score: directed table, then random images
// needs rgbsim_pkg.sv and the block's rtl, nothing else
module tb_rgba_image_similarity_score;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   CH_W       = rgbsim_pkg::CH_W;
    localparam int   SIZE_W     = rgbsim_pkg::SIZE_W;
    localparam int   Q_W        = rgbsim_pkg::Q_W;
    localparam int   MAX_WIDTH  = rgbsim_pkg::MAX_WIDTH;
    localparam int   MAX_HEIGHT = rgbsim_pkg::MAX_HEIGHT;
    localparam logic CFG_WIDTH  = rgbsim_pkg::CFG_WIDTH;
    localparam logic CFG_HEIGHT = rgbsim_pkg::CFG_HEIGHT;

    // bytes from msb: a red, a green, a blue, a alpha, b red, b green, b blue, b alpha
    typedef struct packed {
        logic [CH_W-1:0] a_red;
        logic [CH_W-1:0] a_green;
        logic [CH_W-1:0] a_blue;
        logic [CH_W-1:0] a_alpha;
        logic [CH_W-1:0] b_red;
        logic [CH_W-1:0] b_green;
        logic [CH_W-1:0] b_blue;
        logic [CH_W-1:0] b_alpha;
    } t_pixel_pair;

    typedef enum logic {ROW_SIZE, ROW_PIXEL} t_row_kind;

    // one directed step: a size write, or a pixel request repeated reps times
    typedef struct packed {
        t_row_kind         kind;
        logic              cfg_reg;
        logic [SIZE_W-1:0] cfg_val;
        t_pixel_pair       px;
        int unsigned       reps;
        bit                known;
        logic [Q_W-1:0]    want;
    } t_dir_row;

    // full difference of one pixel pair, 4 * 255
    localparam longint unsigned PIXEL_SPAN = 1020;
    // wait that covers the input stall of the score computation, output load included
    localparam int SETTLE_CYCLES = 32;
    localparam int DRAIN_LIMIT   = 1000;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 100;
    localparam int PHASE_IMAGES  = 2;
    localparam int DIRECTED_ROWS = 23;

    // idle percentages per random phase: none, sender, receiver, both
    localparam int SEND_IDLE [4] = '{0, 63, 0, 20};
    localparam int RECV_IDLE [4] = '{0, 0, 63, 20};

    t_dir_row plan [DIRECTED_ROWS] = '{
        // reset size 64x64, only red differs by full scale: one row, then the height
        // drops to one mid-image and the second row ends it at half scale
        '{ROW_PIXEL, CFG_WIDTH, 13'd0, 64'h00000000_FF000000, 64, 1'b0, 17'd0},
        '{ROW_SIZE, CFG_HEIGHT, 13'd1, 64'h0, 0, 1'b0, 17'd0},
        '{ROW_PIXEL, CFG_WIDTH, 13'd0, 64'h00000000_FF000000, 64, 1'b1, 17'd32768},
        '{ROW_SIZE, CFG_WIDTH, 13'd1, 64'h0, 0, 1'b0, 17'd0},
        '{ROW_SIZE, CFG_HEIGHT, 13'd1, 64'h0, 0, 1'b0, 17'd0},
        // identical, all a high, all b high
        '{ROW_PIXEL, CFG_WIDTH, 13'd0, 64'h00000000_00000000, 1, 1'b1, 17'd65536},
        '{ROW_PIXEL, CFG_WIDTH, 13'd0, 64'hFFFFFFFF_00000000, 1, 1'b1, 17'd0},
        '{ROW_PIXEL, CFG_WIDTH, 13'd0, 64'h00000000_FFFFFFFF, 1, 1'b1, 17'd0},
        '{ROW_PIXEL, CFG_WIDTH, 13'd0, 64'hC80A804D_641E8000, 1, 1'b0, 17'd0},
        '{ROW_PIXEL, CFG_WIDTH, 13'd0, 64'hAA550FF0_55AAF00F, 1, 1'b0, 17'd0},
        '{ROW_PIXEL, CFG_WIDTH, 13'd0, 64'h01000000_00000000, 1, 1'b0, 17'd0},
        // zero sizes read as one
        '{ROW_SIZE, CFG_WIDTH, 13'd0, 64'h0, 0, 1'b0, 17'd0},
        '{ROW_SIZE, CFG_HEIGHT, 13'd0, 64'h0, 0, 1'b0, 17'd0},
        '{ROW_PIXEL, CFG_WIDTH, 13'd0, 64'h00000000_000000FF, 1, 1'b0, 17'd0},
        '{ROW_SIZE, CFG_WIDTH, 13'd3, 64'h0, 0, 1'b0, 17'd0},
        '{ROW_SIZE, CFG_HEIGHT, 13'd2, 64'h0, 0, 1'b0, 17'd0},
        '{ROW_PIXEL, CFG_WIDTH, 13'd0, 64'h0A141E28_281E140A, 6, 1'b0, 17'd0},
        // oversize clamps to 4096x4096, shrunk to 1x1 mid-image: sum beats the divisor,
        // score saturates
        '{ROW_SIZE, CFG_WIDTH, 13'd8191, 64'h0, 0, 1'b0, 17'd0},
        '{ROW_SIZE, CFG_HEIGHT, 13'd8191, 64'h0, 0, 1'b0, 17'd0},
        '{ROW_PIXEL, CFG_WIDTH, 13'd0, 64'hFFFFFFFF_00000000, 5, 1'b0, 17'd0},
        '{ROW_SIZE, CFG_WIDTH, 13'd1, 64'h0, 0, 1'b0, 17'd0},
        '{ROW_SIZE, CFG_HEIGHT, 13'd1, 64'h0, 0, 1'b0, 17'd0},
        '{ROW_PIXEL, CFG_WIDTH, 13'd0, 64'hFFFFFFFF_00000000, 1, 1'b1, 17'd0}
    };

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic              i_cfg_index = 1'b0;
    logic [SIZE_W-1:0] i_cfg_data  = '0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic [CH_W-1:0]   i_a_red     = '0;
    logic [CH_W-1:0]   i_a_green   = '0;
    logic [CH_W-1:0]   i_a_blue    = '0;
    logic [CH_W-1:0]   i_a_alpha   = '0;
    logic [CH_W-1:0]   i_b_red     = '0;
    logic [CH_W-1:0]   i_b_green   = '0;
    logic [CH_W-1:0]   i_b_blue    = '0;
    logic [CH_W-1:0]   i_b_alpha   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [Q_W-1:0]    o_score;

    // shadow of the block: size registers, running sum and raster position
    logic [SIZE_W-1:0] sz_width  = SIZE_W'(64);
    logic [SIZE_W-1:0] sz_height = SIZE_W'(64);
    logic [63:0]       acc_diff  = '0;
    int unsigned       col_pos   = 0;
    int unsigned       row_pos   = 0;

    logic [Q_W-1:0] score_queue [$];
    int             images_done    = 0;
    int             fail_count     = 0;
    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;

    rgba_image_similarity_score dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_a_red     (i_a_red),
        .i_a_green   (i_a_green),
        .i_a_blue    (i_a_blue),
        .i_a_alpha   (i_a_alpha),
        .i_b_red     (i_b_red),
        .i_b_green   (i_b_green),
        .i_b_blue    (i_b_blue),
        .i_b_alpha   (i_b_alpha),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_score     (o_score)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // zero counts as one, anything past the top as the top
    function automatic int unsigned eff_size(input logic [SIZE_W-1:0] v, input int unsigned top);
        if (v == '0) begin
            return 1;
        end
        if (v > top) begin
            return top;
        end
        return 32'(v);
    endfunction

    // advance the shadow by one pixel pair, done marks the last pixel of an image
    function automatic void absorb_pixel(input t_pixel_pair px, output bit done,
                                         output logic [Q_W-1:0] score);
        int unsigned w;
        int unsigned h;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [63:0] full;
        logic [63:0] room;
        w = eff_size(sz_width, MAX_WIDTH);
        h = eff_size(sz_height, MAX_HEIGHT);
        done = 1'b0;
        score = '0;
        for (int k = 0; k < 4; k++) begin
            a = px[(k + 4) * 8 +: 8];
            b = px[k * 8 +: 8];
            acc_diff += (a > b) ? 64'(a - b) : 64'(b - a);
        end
        if (col_pos + 1 < w) begin
            col_pos++;
            return;
        end
        col_pos = 0;
        if (row_pos + 1 < h) begin
            row_pos++;
            return;
        end
        // divisor in force on the last pixel, saturate when the sum overshoots it
        full = PIXEL_SPAN * w * h;
        room = (acc_diff < full) ? full - acc_diff : 64'd0;
        score = Q_W'((room << 16) / full);
        done = 1'b1;
        acc_diff = '0;
        row_pos = 0;
    endfunction

    // mostly tiny images, a few zero sizes
    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 6) begin
            return '0;
        end
        if (r < 75) begin
            return SIZE_W'($urandom_range(5, 1));
        end
        return SIZE_W'($urandom_range(24, 6));
    endfunction

    // random pair: free, identical, near-equal or all-extreme channels
    function automatic t_pixel_pair rand_pixel();
        t_pixel_pair p;
        int unsigned mode;
        mode = $urandom_range(3);
        p = {$urandom, $urandom};
        case (mode)
            1: begin
                p[31:0] = p[63:32];
            end
            2: begin
                for (int k = 0; k < 4; k++) begin
                    p[k * 8 +: 8] = p[(k + 4) * 8 +: 8] + 8'($urandom_range(6)) - 8'd3;
                end
            end
            3: begin
                for (int k = 0; k < 8; k++) begin
                    p[k * 8 +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
                end
            end
            default: begin
            end
        endcase
        return p;
    endfunction

    // one pixel request; on acceptance the shadow advances and any score is queued
    task automatic push_pixel(input t_pixel_pair px, input bit known, input logic [Q_W-1:0] want);
        bit             done;
        logic [Q_W-1:0] score;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        {i_a_red, i_a_green, i_a_blue, i_a_alpha, i_b_red, i_b_green, i_b_blue, i_b_alpha} <= px;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        absorb_pixel(px, done, score);
        if (done) begin
            score_queue.push_back(known ? want : score);
            images_done++;
        end
    endtask

    // size writes only once every score is out and the divider has had time to finish
    task automatic write_size(input logic idx, input logic [SIZE_W-1:0] val);
        i_in_valid <= 1'b0;
        while (score_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_WIDTH) begin
            sz_width = val;
        end else begin
            sz_height = val;
        end
    endtask

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // score checker against the oldest queued expectation
    always @(posedge i_clk) begin : score_check
        logic [Q_W-1:0] expected;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (score_queue.size() == 0) begin
                $error("score %0d arrived with no image pending", o_score);
                fail_count++;
            end else begin
                expected = score_queue.pop_front();
                if (o_score !== expected) begin
                    $error("score mismatch: expected %0d, got %0d", expected, o_score);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: too long without any request moving on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int sent;
        int first_image;
        // synchronous reset, applied once
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, no idling on either side
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (plan[r].kind == ROW_SIZE) begin
                write_size(plan[r].cfg_reg, plan[r].cfg_val);
            end else begin
                for (int n = 0; n < plan[r].reps; n++) begin
                    push_pixel(plan[r].px, plan[r].known, plan[r].want);
                end
            end
        end

        // random images, each phase ends on an image boundary
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_IDLE[ph];
            sent = 0;
            first_image = images_done;
            while (sent < PHASE_ITEMS || images_done - first_image < PHASE_IMAGES ||
                   col_pos != 0 || row_pos != 0) begin
                if (col_pos == 0 && row_pos == 0) begin
                    if ($urandom_range(99) < 50) begin
                        write_size(CFG_WIDTH, pick_size());
                    end
                    if ($urandom_range(99) < 50) begin
                        write_size(CFG_HEIGHT, pick_size());
                    end
                end else if ($urandom_range(99) < 2) begin
                    // resize in the middle of an image
                    write_size($urandom_range(1) ? CFG_HEIGHT : CFG_WIDTH, pick_size());
                end
                push_pixel(rand_pixel(), 1'b0, '0);
                sent++;
            end
        end

        // drain, then let the block sit idle for a while
        i_in_valid <= 1'b0;
        for (int k = 0; k < DRAIN_LIMIT && score_queue.size() != 0; k++) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (score_queue.size() != 0) begin
            $error("%0d scores never arrived", score_queue.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/rgbsim_pkg.sv
hw/rtl/rgba_image_similarity_score.sv
verif/tb_rgba_image_similarity_score.sv
